/* rtl/core/bsc_pkg.sv */
// shared types and constants for the banker's safety check block
package bsc_pkg;

   localparam int FIELD_IDX_W = 4;
   localparam int AMOUNT_W    = 8;
   localparam int WORK_W      = 16;
   localparam int COUNT_W     = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int FUNC_W      = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD_CLAIM = 2'd0,
      FUNC_LOAD_ALLOC = 2'd1,
      FUNC_LOAD_TOTAL = 2'd2,
      FUNC_CHECK      = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_PROCESSES = 2'd0,
      CSR_NUM_RESOURCES = 2'd1
   } csr_index_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic start;
      logic acc_load;
      logic acc_sub;
      logic i_inc;
      logic i_clr;
      logic j_inc;
      logic j_clr;
      logic work_init_wr;
      logic work_add_wr;
      logic mark_grant;
      logic pass_clr;
      logic emit_grant;
      logic emit_verdict;
   } bsc_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic i_last;
      logic j_last;
      logic finished;
      logic fits;
      logic all_done;
      logic progress;
      logic out_free;
   } bsc_status_type;

endpackage

/* rtl/core/bsc_if.sv */
// request, response and register-write channel interfaces
interface bsc_req_if import bsc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [FUNC_W-1:0]      func;
   logic [FIELD_IDX_W-1:0] process_index;
   logic [FIELD_IDX_W-1:0] resource_index;
   logic [AMOUNT_W-1:0]    amount;

   modport source (output valid, func, process_index, resource_index, amount, input ready);
   modport sink   (input valid, func, process_index, resource_index, amount, output ready);
endinterface

interface bsc_rsp_if import bsc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [FIELD_IDX_W-1:0] granted_process;
   logic                   is_verdict;
   logic                   safe;
   logic                   last;

   modport source (output valid, granted_process, is_verdict, safe, last, input ready);
   modport sink   (input valid, granted_process, is_verdict, safe, last, output ready);
endinterface

interface bsc_csr_if import bsc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [COUNT_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/bsc_ram.sv */
// generic single-write, single-read ram with registered read data
module bsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/bsc_datapath.sv */
// matrices, work vector, walk counters, finish flags and result register
module bsc_datapath import bsc_pkg::*; #(
   parameter int MAX_PROCS = 16,
   parameter int MAX_RES   = 16,
   localparam int PCNT_W   = $clog2(MAX_PROCS + 1),
   localparam int RCNT_W   = $clog2(MAX_RES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bsc_cmd_type            cmd,
   output bsc_status_type         status,
   input  logic [FUNC_W-1:0]      ld_func,
   input  logic [FIELD_IDX_W-1:0] ld_process,
   input  logic [FIELD_IDX_W-1:0] ld_resource,
   input  logic [AMOUNT_W-1:0]    ld_amount,
   input  logic [PCNT_W-1:0]      proc_count,
   input  logic [RCNT_W-1:0]      res_count,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [FIELD_IDX_W-1:0] rsp_granted_process,
   output logic                   rsp_is_verdict,
   output logic                   rsp_safe,
   output logic                   rsp_last
);

   localparam int PW     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int RW     = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
   localparam int MAT_AW = PW + RW;
   localparam int PCMP_W = PCNT_W + 1;
   localparam int RCMP_W = RCNT_W + 1;

   logic [PW-1:0]              i_ff;
   logic [RW-1:0]              j_ff;
   logic [MAX_PROCS-1:0]       fin_ff;
   logic [PCNT_W-1:0]          done_ff;
   logic                       progress_ff;
   logic signed [WORK_W-1:0]   acc_ff;
   logic                       out_valid_ff;
   logic [FIELD_IDX_W-1:0]     out_proc_ff;
   logic                       out_verdict_ff;
   logic                       out_safe_ff;

   logic                       proc_ok;
   logic                       res_ok;
   logic                       claim_we;
   logic                       alloc_we;
   logic                       total_we;
   logic [MAT_AW-1:0]          mat_waddr;
   logic [MAT_AW-1:0]          mat_raddr;
   logic [AMOUNT_W-1:0]        claim_rdata;
   logic [AMOUNT_W-1:0]        alloc_rdata;
   logic [AMOUNT_W-1:0]        total_rdata;
   logic                       work_we;
   logic [WORK_W-1:0]          work_wdata;
   logic signed [WORK_W-1:0]   work_rdata;
   logic signed [AMOUNT_W:0]   need;
   logic signed [WORK_W-1:0]   need_ext;
   logic                       all_done;

   // load decode; rows or columns beyond storage are dropped
   assign proc_ok   = int'(ld_process) < MAX_PROCS;
   assign res_ok    = int'(ld_resource) < MAX_RES;
   assign claim_we  = cmd.load && (ld_func == FUNC_LOAD_CLAIM) && proc_ok && res_ok;
   assign alloc_we  = cmd.load && (ld_func == FUNC_LOAD_ALLOC) && proc_ok && res_ok;
   assign total_we  = cmd.load && (ld_func == FUNC_LOAD_TOTAL) && res_ok;
   assign mat_waddr = {PW'(ld_process), RW'(ld_resource)};
   assign mat_raddr = {i_ff, j_ff};

   bsc_ram #(.WIDTH(AMOUNT_W), .DEPTH(2 ** MAT_AW)) u_claim (
      .clock (clock),
      .we    (claim_we),
      .waddr (mat_waddr),
      .wdata (ld_amount),
      .raddr (mat_raddr),
      .rdata (claim_rdata)
   );

   bsc_ram #(.WIDTH(AMOUNT_W), .DEPTH(2 ** MAT_AW)) u_alloc (
      .clock (clock),
      .we    (alloc_we),
      .waddr (mat_waddr),
      .wdata (ld_amount),
      .raddr (mat_raddr),
      .rdata (alloc_rdata)
   );

   bsc_ram #(.WIDTH(AMOUNT_W), .DEPTH(2 ** RW)) u_total (
      .clock (clock),
      .we    (total_we),
      .waddr (RW'(ld_resource)),
      .wdata (ld_amount),
      .raddr (j_ff),
      .rdata (total_rdata)
   );

   assign work_we    = cmd.work_init_wr || cmd.work_add_wr;
   assign work_wdata = cmd.work_init_wr ? acc_ff
                                        : WORK_W'(work_rdata + $signed({1'b0, alloc_rdata}));

   bsc_ram #(.WIDTH(WORK_W), .DEPTH(2 ** RW)) u_work (
      .clock (clock),
      .we    (work_we),
      .waddr (j_ff),
      .wdata (work_wdata),
      .raddr (j_ff),
      .rdata (work_rdata)
   );

   // need = claim - alloc, compared signed against work
   assign need     = $signed({1'b0, claim_rdata}) - $signed({1'b0, alloc_rdata});
   assign need_ext = WORK_W'(need);
   assign all_done = (done_ff == proc_count);

   always_comb begin
      status.i_last   = (PCMP_W'(i_ff) + 1'b1) == PCMP_W'(proc_count);
      status.j_last   = (RCMP_W'(j_ff) + 1'b1) == RCMP_W'(res_count);
      status.finished = fin_ff[i_ff];
      status.fits     = !(need_ext > work_rdata);
      status.all_done = all_done;
      status.progress = progress_ff;
      status.out_free = !out_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff         <= '0;
         j_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.i_clr) begin
            i_ff <= '0;
         end else if (cmd.i_inc) begin
            i_ff <= i_ff + 1'b1;
         end
         if (cmd.j_clr) begin
            j_ff <= '0;
         end else if (cmd.j_inc) begin
            j_ff <= j_ff + 1'b1;
         end
         if (cmd.emit_grant || cmd.emit_verdict) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         fin_ff  <= '0;
         done_ff <= '0;
      end else if (cmd.mark_grant) begin
         fin_ff[i_ff] <= 1'b1;
         done_ff      <= done_ff + 1'b1;
      end
      if (cmd.pass_clr) begin
         progress_ff <= 1'b0;
      end else if (cmd.mark_grant) begin
         progress_ff <= 1'b1;
      end
      if (cmd.acc_load) begin
         acc_ff <= $signed(WORK_W'(total_rdata));
      end else if (cmd.acc_sub) begin
         acc_ff <= acc_ff - $signed(WORK_W'(alloc_rdata));
      end
      if (cmd.emit_grant) begin
         out_proc_ff    <= FIELD_IDX_W'(i_ff);
         out_verdict_ff <= 1'b0;
         out_safe_ff    <= 1'b0;
      end else if (cmd.emit_verdict) begin
         out_proc_ff    <= '0;
         out_verdict_ff <= 1'b1;
         out_safe_ff    <= all_done;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_granted_process = out_proc_ff;
   assign rsp_is_verdict      = out_verdict_ff;
   assign rsp_safe            = out_safe_ff;
   assign rsp_last            = out_verdict_ff;

endmodule

/* rtl/core/bsc_ctrl.sv */
// state machine that sequences loads, work setup and the grant passes
module bsc_ctrl import bsc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [FUNC_W-1:0] req_func,
   input  bsc_status_type    status,
   output logic              req_ready,
   output bsc_cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT_TOT,
      S_INIT_LD,
      S_SUM_RD,
      S_SUM_ACC,
      S_INIT_WR,
      S_FIT_RD,
      S_FIT_CMP,
      S_GRANT_RD,
      S_GRANT_WR,
      S_EMIT_GRANT,
      S_NEXT_PROC,
      S_VERDICT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_CHECK) begin
                  cmd.start = 1'b1;
                  cmd.i_clr = 1'b1;
                  cmd.j_clr = 1'b1;
                  state_in  = S_INIT_TOT;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         S_INIT_TOT: begin
            state_in = S_INIT_LD;
         end
         S_INIT_LD: begin
            cmd.acc_load = 1'b1;
            state_in     = S_SUM_ACC;
         end
         S_SUM_RD: begin
            state_in = S_SUM_ACC;
         end
         S_SUM_ACC: begin
            cmd.acc_sub = 1'b1;
            if (status.i_last) begin
               cmd.i_clr = 1'b1;
               state_in  = S_INIT_WR;
            end else begin
               cmd.i_inc = 1'b1;
               state_in  = S_SUM_RD;
            end
         end
         S_INIT_WR: begin
            cmd.work_init_wr = 1'b1;
            if (status.j_last) begin
               cmd.j_clr    = 1'b1;
               cmd.pass_clr = 1'b1;
               state_in     = S_FIT_RD;
            end else begin
               cmd.j_inc = 1'b1;
               state_in  = S_INIT_TOT;
            end
         end
         S_FIT_RD: begin
            if (status.finished) begin
               state_in = S_NEXT_PROC;
            end else begin
               state_in = S_FIT_CMP;
            end
         end
         S_FIT_CMP: begin
            if (!status.fits) begin
               cmd.j_clr = 1'b1;
               state_in  = S_NEXT_PROC;
            end else if (status.j_last) begin
               cmd.j_clr = 1'b1;
               state_in  = S_GRANT_RD;
            end else begin
               cmd.j_inc = 1'b1;
               state_in  = S_FIT_RD;
            end
         end
         S_GRANT_RD: begin
            state_in = S_GRANT_WR;
         end
         S_GRANT_WR: begin
            cmd.work_add_wr = 1'b1;
            if (status.j_last) begin
               cmd.j_clr      = 1'b1;
               cmd.mark_grant = 1'b1;
               state_in       = S_EMIT_GRANT;
            end else begin
               cmd.j_inc = 1'b1;
               state_in  = S_GRANT_RD;
            end
         end
         S_EMIT_GRANT: begin
            if (status.out_free) begin
               cmd.emit_grant = 1'b1;
               state_in       = S_NEXT_PROC;
            end
         end
         S_NEXT_PROC: begin
            if (!status.i_last) begin
               cmd.i_inc = 1'b1;
               state_in  = S_FIT_RD;
            end else if (status.all_done || !status.progress) begin
               state_in = S_VERDICT;
            end else begin
               // another pass over all processes
               cmd.i_clr    = 1'b1;
               cmd.pass_clr = 1'b1;
               state_in     = S_FIT_RD;
            end
         end
         S_VERDICT: begin
            if (status.out_free) begin
               cmd.emit_verdict = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/bankers_safety_check_top.sv */
// Banker's-algorithm safety check. Load transfers (claim, allocation, total)
// are written to on-chip RAM as they are accepted. A check transfer runs a
// sequencer over single-write, single-read registered RAMs. Work setup takes
// each process's allocation off the total for every resource in use. Each
// visit to an unfinished process in a pass compares its need against work
// resource by resource; a finished process is passed over. A grant adds the
// process's allocation back to work. A stalled response holds the sequencer
// until the result register is free. One grant transfer per granted process
// appears on the response channel, then a verdict transfer marked last. The
// request channel is held off until the verdict is registered. Counts of 0
// act as 1, and counts above the storage act as the storage size.
module bankers_safety_check_top import bsc_pkg::*; #(
   parameter int MAX_PROCS = 16,
   parameter int MAX_RES   = 16
) (
   input logic        clock,
   input logic        reset,
   bsc_req_if.sink    req_if,
   bsc_rsp_if.source  rsp_if,
   bsc_csr_if.sink    csr_if
);

   localparam int PCNT_W = $clog2(MAX_PROCS + 1);
   localparam int RCNT_W = $clog2(MAX_RES + 1);

   logic [COUNT_W-1:0] num_processes_ff;
   logic [COUNT_W-1:0] num_resources_ff;
   logic [PCNT_W-1:0]  proc_count;
   logic [RCNT_W-1:0]  res_count;
   bsc_cmd_type        cmd;
   bsc_status_type     status;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_processes_ff <= COUNT_W'(1);
         num_resources_ff <= COUNT_W'(1);
      end else if (csr_if.valid) begin
         unique case (csr_index_type'(csr_if.index))
            CSR_NUM_PROCESSES: num_processes_ff <= csr_if.data;
            CSR_NUM_RESOURCES: num_resources_ff <= csr_if.data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (num_processes_ff == '0) begin
         proc_count = PCNT_W'(1);
      end else if (int'(num_processes_ff) > MAX_PROCS) begin
         proc_count = PCNT_W'(MAX_PROCS);
      end else begin
         proc_count = PCNT_W'(num_processes_ff);
      end
      if (num_resources_ff == '0) begin
         res_count = RCNT_W'(1);
      end else if (int'(num_resources_ff) > MAX_RES) begin
         res_count = RCNT_W'(MAX_RES);
      end else begin
         res_count = RCNT_W'(num_resources_ff);
      end
   end

   bsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_func  (req_if.func),
      .status    (status),
      .req_ready (req_if.ready),
      .cmd       (cmd)
   );

   bsc_datapath #(.MAX_PROCS(MAX_PROCS), .MAX_RES(MAX_RES)) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .ld_func             (req_if.func),
      .ld_process          (req_if.process_index),
      .ld_resource         (req_if.resource_index),
      .ld_amount           (req_if.amount),
      .proc_count          (proc_count),
      .res_count           (res_count),
      .rsp_ready           (rsp_if.ready),
      .rsp_valid           (rsp_if.valid),
      .rsp_granted_process (rsp_if.granted_process),
      .rsp_is_verdict      (rsp_if.is_verdict),
      .rsp_safe            (rsp_if.safe),
      .rsp_last            (rsp_if.last)
   );

endmodule

/* rtl/core/bsc_checker.sv */
// port-level checks for the safety check block, bound to the top level
module bsc_checker import bsc_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic [FUNC_W-1:0]      req_func,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [FIELD_IDX_W-1:0] rsp_granted_process,
   input logic                   rsp_is_verdict,
   input logic                   rsp_safe,
   input logic                   rsp_last
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_granted_process) && $stable(rsp_is_verdict)
                                  && $stable(rsp_safe) && $stable(rsp_last))
      else $error("stalled result changed");

   // only the verdict closes a run
   a_last_is_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last == rsp_is_verdict)
      else $error("last flag not matching verdict");

   // grants carry no safe flag
   a_grant_not_safe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_verdict |-> !rsp_safe)
      else $error("grant result marked safe");

   // a check transfer holds off further requests
   a_check_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == FUNC_CHECK |=> !req_ready)
      else $error("request taken while check runs");

endmodule

bind bankers_safety_check_top bsc_checker u_bsc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_if.valid),
   .req_ready           (req_if.ready),
   .req_func            (req_if.func),
   .rsp_valid           (rsp_if.valid),
   .rsp_ready           (rsp_if.ready),
   .rsp_granted_process (rsp_if.granted_process),
   .rsp_is_verdict      (rsp_if.is_verdict),
   .rsp_safe            (rsp_if.safe),
   .rsp_last            (rsp_if.last)
);

/* tb/sv/bankers_safety_check_checker.sv */
// predictor and result checker for the banker's safety check block
`timescale 1ns / 100ps
module bankers_safety_check_checker import bsc_pkg::*; #(
   parameter int MAX_PROCS = 16,
   parameter int MAX_RES   = 16
) (
   input  logic clock,
   input  logic reset,
   bsc_req_if   req_if,
   bsc_rsp_if   rsp_if,
   bsc_csr_if   csr_if,
   output int   fail_count,
   output int   pending_count,
   output int   proc_count,
   output int   res_count
);

   typedef struct packed {
      logic [FIELD_IDX_W-1:0] granted_process;
      logic                   is_verdict;
      logic                   safe;
      logic                   last;
   } grant_result_type;

   logic [AMOUNT_W-1:0] claim_mem [MAX_PROCS][MAX_RES];
   logic [AMOUNT_W-1:0] alloc_mem [MAX_PROCS][MAX_RES];
   logic [AMOUNT_W-1:0] total_mem [MAX_RES];
   logic [COUNT_W-1:0]  procs_reg;
   logic [COUNT_W-1:0]  res_reg;
   grant_result_type    grant_queue [$];
   grant_result_type    seen;
   grant_result_type    wanted;

   function automatic int clamp_count(logic [COUNT_W-1:0] value, int limit);
      if (value == 0) return 1;
      return (value > limit) ? limit : int'(value);
   endfunction

   assign proc_count = clamp_count(procs_reg, MAX_PROCS);
   assign res_count  = clamp_count(res_reg, MAX_RES);

   function automatic void check_field(string field, int expected_value, int actual_value);
      if (expected_value != actual_value) begin
         $error("%s: expected %0d, got %0d", field, expected_value, actual_value);
         fail_count++;
      end
   endfunction

   // queues one grant per granted process, then the verdict
   function automatic void predict_safety_check();
      logic signed [WORK_W-1:0] work [MAX_RES];
      logic                     finished [MAX_PROCS];
      int                       col_sum;
      int                       need;
      int                       granted;
      logic                     fits;
      logic                     progress;
      for (int j = 0; j < res_count; j++) begin
         col_sum = 0;
         for (int i = 0; i < proc_count; i++) col_sum += int'(alloc_mem[i][j]);
         work[j] = WORK_W'(int'(total_mem[j]) - col_sum);
      end
      for (int i = 0; i < MAX_PROCS; i++) finished[i] = 1'b0;
      granted = 0;
      do begin
         progress = 1'b0;
         for (int i = 0; i < proc_count; i++) begin
            if (!finished[i]) begin
               fits = 1'b1;
               for (int j = 0; j < res_count; j++) begin
                  need = int'(claim_mem[i][j]) - int'(alloc_mem[i][j]);
                  if (need > int'(work[j])) fits = 1'b0;
               end
               if (fits) begin
                  for (int j = 0; j < res_count; j++)
                     work[j] = WORK_W'(int'(work[j]) + int'(alloc_mem[i][j]));
                  finished[i] = 1'b1;
                  granted++;
                  progress = 1'b1;
                  grant_queue.push_back('{granted_process: FIELD_IDX_W'(i), is_verdict: 1'b0,
                                          safe: 1'b0, last: 1'b0});
               end
            end
         end
      end while (progress && granted < proc_count);
      grant_queue.push_back('{granted_process: '0, is_verdict: 1'b1,
                              safe: (granted == proc_count), last: 1'b1});
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         procs_reg = 1;
         res_reg   = 1;
         grant_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            seen = '{rsp_if.granted_process, rsp_if.is_verdict, rsp_if.safe, rsp_if.last};
            if (grant_queue.size() == 0) begin
               $error("result transfer with nothing expected: granted_process %0d is_verdict %0d",
                      seen.granted_process, seen.is_verdict);
               fail_count++;
            end else begin
               wanted = grant_queue.pop_front();
               check_field("granted_process", wanted.granted_process, seen.granted_process);
               check_field("is_verdict", wanted.is_verdict, seen.is_verdict);
               check_field("safe", wanted.safe, seen.safe);
               check_field("last", wanted.last, seen.last);
            end
         end
         if (csr_if.valid && csr_if.ready) begin
            case (csr_index_type'(csr_if.index))
               CSR_NUM_PROCESSES: procs_reg = csr_if.data;
               CSR_NUM_RESOURCES: res_reg = csr_if.data;
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            case (func_type'(req_if.func))
               FUNC_LOAD_CLAIM: claim_mem[req_if.process_index][req_if.resource_index] =
                                req_if.amount;
               FUNC_LOAD_ALLOC: alloc_mem[req_if.process_index][req_if.resource_index] =
                                req_if.amount;
               FUNC_LOAD_TOTAL: total_mem[req_if.resource_index] = req_if.amount;
               FUNC_CHECK:      predict_safety_check();
               default: ;
            endcase
         end
      end
      pending_count = grant_queue.size();
   end

endmodule

/* tb/sv/bankers_safety_check_top_test.sv */
// stimulus, clock, reset and final verdict for the banker's safety check block
`timescale 1ns / 100ps
module bankers_safety_check_top_test;
   import bsc_pkg::*;

   localparam int MAX_PROCS  = 16;
   localparam int MAX_RES    = 16;
   localparam int AMOUNT_MAX = (1 << AMOUNT_W) - 1;
   localparam int COUNT_MAX  = (1 << COUNT_W) - 1;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   proc_count;
   int   res_count;
   int   requests_sent;
   int   checks_sent;
   int   results_seen;
   bit   quiet;
   bit   req_gaps;

   // what the stimulus has written so far, used to shape amounts and avoid unwritten reads
   logic [AMOUNT_W-1:0] claim_val [MAX_PROCS][MAX_RES];
   logic [AMOUNT_W-1:0] alloc_val [MAX_PROCS][MAX_RES];
   logic [AMOUNT_W-1:0] total_val [MAX_RES];
   bit                  claim_set [MAX_PROCS][MAX_RES];
   bit                  alloc_set [MAX_PROCS][MAX_RES];
   bit                  total_set [MAX_RES];

   bsc_req_if req_if ();
   bsc_rsp_if rsp_if ();
   bsc_csr_if csr_if ();

   bankers_safety_check_top #(.MAX_PROCS(MAX_PROCS), .MAX_RES(MAX_RES)) dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if)
   );

   bankers_safety_check_checker #(.MAX_PROCS(MAX_PROCS), .MAX_RES(MAX_RES)) grant_checker (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if),
      .fail_count(fail_count),
      .pending_count(pending_count),
      .proc_count(proc_count),
      .res_count(res_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("timeout: run did not complete");
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) results_seen <= results_seen + 1;
   end

   // result side back-pressure
   initial begin
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   task automatic send_request(func_type func, logic [FIELD_IDX_W-1:0] proc,
                               logic [FIELD_IDX_W-1:0] res, logic [AMOUNT_W-1:0] amount);
      if (req_gaps && !quiet && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.func           <= func;
      req_if.process_index  <= proc;
      req_if.resource_index <= res;
      req_if.amount         <= amount;
      do @(negedge clock); while (!req_if.ready);
      @(posedge clock);
      requests_sent++;
      case (func)
         FUNC_LOAD_CLAIM: begin
            claim_val[proc][res] = amount;
            claim_set[proc][res] = 1'b1;
         end
         FUNC_LOAD_ALLOC: begin
            alloc_val[proc][res] = amount;
            alloc_set[proc][res] = 1'b1;
         end
         FUNC_LOAD_TOTAL: begin
            total_val[res] = amount;
            total_set[res] = 1'b1;
         end
         FUNC_CHECK: checks_sent++;
         default: ;
      endcase
   endtask

   // drop valid, drain every expected result, then give trailing loads time to land
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type index, logic [COUNT_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= value;
      do @(negedge clock); while (!csr_if.ready);
      @(posedge clock);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int alloc_column_sum(int res);
      int sum = 0;
      for (int p = 0; p < proc_count; p++) sum += alloc_val[p][res];
      return sum;
   endfunction

   // mostly claim at or above allocation, now and then below it
   function automatic logic [AMOUNT_W-1:0] claim_amount(int proc, int res);
      int amount = alloc_val[proc][res] + $urandom_range(0, 9);
      if ($urandom_range(0, 7) == 0) amount = $urandom_range(0, alloc_val[proc][res]);
      return AMOUNT_W'((amount > AMOUNT_MAX) ? AMOUNT_MAX : amount);
   endfunction

   // total close to what is allocated, so some checks come out safe
   function automatic logic [AMOUNT_W-1:0] total_amount(int res);
      int amount = alloc_column_sum(res) + $urandom_range(0, 12);
      return AMOUNT_W'((amount > AMOUNT_MAX) ? AMOUNT_MAX : amount);
   endfunction

   // writes every entry in use, or only the ones never written
   task automatic load_tables(bit rewrite);
      for (int p = 0; p < proc_count; p++) begin
         for (int r = 0; r < res_count; r++) begin
            if (rewrite || !alloc_set[p][r])
               send_request(FUNC_LOAD_ALLOC, FIELD_IDX_W'(p), FIELD_IDX_W'(r),
                            AMOUNT_W'($urandom_range(0, 7)));
            if (rewrite || !claim_set[p][r])
               send_request(FUNC_LOAD_CLAIM, FIELD_IDX_W'(p), FIELD_IDX_W'(r),
                            claim_amount(p, r));
         end
      end
      for (int r = 0; r < res_count; r++) begin
         if (rewrite || !total_set[r])
            send_request(FUNC_LOAD_TOTAL, FIELD_IDX_W'($urandom_range(0, MAX_PROCS - 1)),
                         FIELD_IDX_W'(r), total_amount(r));
      end
   endtask

   task automatic tweak_tables(int count);
      int       p;
      int       r;
      func_type func;
      repeat (count) begin
         func = func_type'($urandom_range(FUNC_LOAD_CLAIM, FUNC_LOAD_TOTAL));
         p = $urandom_range(0, proc_count - 1);
         r = $urandom_range(0, res_count - 1);
         if ($urandom_range(0, 5) == 0) begin
            // anywhere in storage, any amount
            send_request(func, FIELD_IDX_W'($urandom_range(0, MAX_PROCS - 1)),
                         FIELD_IDX_W'($urandom_range(0, MAX_RES - 1)), AMOUNT_W'($urandom()));
         end else begin
            case (func)
               FUNC_LOAD_CLAIM: send_request(func, FIELD_IDX_W'(p), FIELD_IDX_W'(r),
                                             claim_amount(p, r));
               FUNC_LOAD_ALLOC: send_request(func, FIELD_IDX_W'(p), FIELD_IDX_W'(r),
                                             AMOUNT_W'($urandom_range(0, 7)));
               FUNC_LOAD_TOTAL: send_request(func, FIELD_IDX_W'(p), FIELD_IDX_W'(r),
                                             total_amount(r));
               default: ;
            endcase
         end
      end
   endtask

   task automatic run_check();
      load_tables(1'b0);
      send_request(FUNC_CHECK, FIELD_IDX_W'($urandom()), FIELD_IDX_W'($urandom()),
                   AMOUNT_W'($urandom()));
   endtask

   // small counts keep the number of loads down; zero acts as one
   function automatic logic [COUNT_W-1:0] pick_count();
      if ($urandom_range(0, 4) == 0) return '0;
      return COUNT_W'($urandom_range(1, 3));
   endfunction

   initial begin
      int phase;
      int guard;
      reset                 <= 1'b1;
      req_if.valid          <= 1'b0;
      req_if.func           <= FUNC_LOAD_CLAIM;
      req_if.process_index  <= '0;
      req_if.resource_index <= '0;
      req_if.amount         <= '0;
      csr_if.valid          <= 1'b0;
      csr_if.index          <= CSR_NUM_PROCESSES;
      csr_if.data           <= '0;
      results_seen          <= 0;
      requests_sent = 0;
      checks_sent   = 0;
      quiet         = 1'b0;
      req_gaps      = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one process, one resource: need equal to work
      send_request(FUNC_LOAD_TOTAL, 4'd0, 4'd0, 8'd255);
      send_request(FUNC_LOAD_CLAIM, 4'd0, 4'd0, 8'd255);
      send_request(FUNC_LOAD_ALLOC, 4'd0, 4'd0, 8'd0);
      run_check();
      // claim below allocation
      send_request(FUNC_LOAD_CLAIM, 4'd0, 4'd0, 8'd0);
      send_request(FUNC_LOAD_ALLOC, 4'd0, 4'd0, 8'd255);
      run_check();
      // work starts negative
      send_request(FUNC_LOAD_TOTAL, 4'd0, 4'd0, 8'd0);
      run_check();
      // nothing fits, unsafe with no grant
      send_request(FUNC_LOAD_CLAIM, 4'd0, 4'd0, 8'd255);
      send_request(FUNC_LOAD_ALLOC, 4'd0, 4'd0, 8'd0);
      run_check();
      // top corners of storage, outside the counts in use
      send_request(FUNC_LOAD_CLAIM, 4'd15, 4'd15, AMOUNT_W'($urandom()));
      send_request(FUNC_LOAD_ALLOC, 4'd15, 4'd15, AMOUNT_W'($urandom()));
      send_request(FUNC_LOAD_TOTAL, 4'd15, 4'd15, AMOUNT_W'($urandom()));
      wait_idle();

      // two processes, zero resources acting as one: second one granted first,
      // first one only on the second pass
      write_csr(CSR_NUM_PROCESSES, 5'd2);
      write_csr(CSR_NUM_RESOURCES, 5'd0);
      send_request(FUNC_LOAD_CLAIM, 4'd0, 4'd0, 8'd5);
      send_request(FUNC_LOAD_ALLOC, 4'd0, 4'd0, 8'd0);
      send_request(FUNC_LOAD_CLAIM, 4'd1, 4'd0, 8'd2);
      send_request(FUNC_LOAD_ALLOC, 4'd1, 4'd0, 8'd1);
      send_request(FUNC_LOAD_TOTAL, 4'd0, 4'd0, 8'd5);
      run_check();
      wait_idle();

      // process count above storage size, zero resources acting as one
      write_csr(CSR_NUM_PROCESSES, COUNT_W'(COUNT_MAX));
      write_csr(CSR_NUM_RESOURCES, 5'd0);
      load_tables(1'b0);
      send_request(FUNC_LOAD_TOTAL, 4'd0, 4'd0, total_amount(0));
      run_check();
      wait_idle();

      // resource count above storage size, zero processes acting as one
      write_csr(CSR_NUM_PROCESSES, 5'd0);
      write_csr(CSR_NUM_RESOURCES, 5'd17);
      run_check();

      for (phase = 0; phase < 30 && requests_sent < 100; phase++) begin
         wait_idle();
         req_gaps = $urandom_range(0, 3) != 0;
         write_csr(CSR_NUM_PROCESSES, pick_count());
         write_csr(CSR_NUM_RESOURCES, pick_count());
         load_tables(proc_count * res_count <= 4 && $urandom_range(0, 2) != 0);
         repeat ($urandom_range(1, 2)) begin
            tweak_tables($urandom_range(0, 2));
            run_check();
         end
      end

      // closing stretch with no idling on either side
      wait_idle();
      quiet = 1'b1;
      write_csr(CSR_NUM_PROCESSES, COUNT_W'($urandom_range(2, 3)));
      write_csr(CSR_NUM_RESOURCES, COUNT_W'($urandom_range(1, 2)));
      load_tables(1'b1);
      repeat (2) begin
         tweak_tables(1);
         run_check();
      end
      req_if.valid <= 1'b0;
      for (guard = 0; guard < 200000 && pending_count != 0; guard++) @(negedge clock);
      repeat (50) @(posedge clock);

      if (pending_count != 0) $error("%0d expected results never arrived", pending_count);
      $display("sent %0d requests with %0d safety checks; %0d result transfers checked",
               requests_sent, checks_sent, results_seen);
      $display("counts swept from zero through storage size and beyond, gaps and stalls mixed");
      if (fail_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
